// File: rtl/history_ring_multi_reader_assert.svh
// Assertion macros shared by the history ring RTL.
`ifndef HISTORY_RING_MULTI_READER_ASSERT_SVH
`define HISTORY_RING_MULTI_READER_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define HRMR_CHECK(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("hrmr check failed");

// Check that cons holds in the cycle after ante.
`define HRMR_CHECK_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("hrmr check failed");

`endif

// File: rtl/hrmr_pkg.sv
// Shared constants and types for the history ring with reader slots.
package hrmr_pkg;

   localparam int HISTORY_DEPTH = 60;
   localparam int READER_SLOTS  = 5;
   localparam int WORD_WIDTH    = 64;

   localparam int PTR_W  = $clog2(HISTORY_DEPTH);
   localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
   localparam int OP_W   = 2;
   localparam int ID_W   = 16;
   localparam int SLOT_W = 3;
   localparam int PAY_W  = 64;
   localparam int REM_W  = 6;
   localparam int RCNT_W = 3;

   localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
   localparam logic [OP_W-1:0] OP_ATTACH = 2'd1;
   localparam logic [OP_W-1:0] OP_DETACH = 2'd2;
   localparam logic [OP_W-1:0] OP_FETCH  = 2'd3;

   // Operation handed to the slot table on a transfer.
   typedef struct packed {
      logic              accept;
      logic [OP_W-1:0]   opcode;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] slot;
   } st_req_type;

   // Slot table answer plus ring memory controls.
   typedef struct packed {
      logic              success;
      logic [ID_W-1:0]   rid;
      logic [REM_W-1:0]  rem;
      logic              live;
      logic [RCNT_W-1:0] rcount;
      logic              pending;
      logic              rec_en;
      logic              rd_en;
      logic [PTR_W-1:0]  rd_addr;
   } st_rsp_type;

endpackage

// File: rtl/hrmr_ram.sv
// Single write port, single read port RAM with registered read data.
module hrmr_ram #(
   parameter int DEPTH = 60,
   parameter int WIDTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/hrmr_ring_ctrl.sv
// Ring start and fill count with the append address.
module hrmr_ring_ctrl
   import hrmr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             rec_en,
   output logic [PTR_W-1:0] ring_start,
   output logic [CNT_W-1:0] ring_count,
   output logic [PTR_W-1:0] wr_addr
);

   localparam int SUM_W = CNT_W + 1;

   logic [PTR_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [SUM_W-1:0] pos_sum;

   // Wrap start + count back into the ring
   always_comb begin
      pos_sum = SUM_W'(start_ff) + SUM_W'(count_ff);
      if (pos_sum >= SUM_W'(HISTORY_DEPTH)) begin
         wr_addr = PTR_W'(pos_sum - SUM_W'(HISTORY_DEPTH));
      end else begin
         wr_addr = PTR_W'(pos_sum);
      end
   end

   // Grow until full, then drop the oldest word
   always_comb begin
      start_in = start_ff;
      count_in = count_ff;
      if (rec_en) begin
         if (count_ff < CNT_W'(HISTORY_DEPTH)) begin
            count_in = count_ff + CNT_W'(1);
         end else if (start_ff == PTR_W'(HISTORY_DEPTH - 1)) begin
            start_in = '0;
         end else begin
            start_in = start_ff + PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= '0;
         count_ff <= '0;
      end else begin
         start_ff <= start_in;
         count_ff <= count_in;
      end
   end

   assign ring_start = start_ff;
   assign ring_count = count_ff;

endmodule

// File: rtl/hrmr_slot_table.sv
// Reader slot table: attach, detach, fetch cursors and record gating.
`include "history_ring_multi_reader_assert.svh"

module hrmr_slot_table
   import hrmr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  st_req_type       req,
   input  logic [PTR_W-1:0] ring_start,
   input  logic [CNT_W-1:0] ring_count,
   output st_rsp_type       rsp
);

   logic [READER_SLOTS-1:0] valid_ff, valid_in;
   logic [ID_W-1:0]         reader_ff [READER_SLOTS];
   logic [ID_W-1:0]         reader_in [READER_SLOTS];
   logic [PTR_W-1:0]        cursor_ff [READER_SLOTS];
   logic [PTR_W-1:0]        cursor_in [READER_SLOTS];
   logic [CNT_W-1:0]        remain_ff [READER_SLOTS];
   logic [CNT_W-1:0]        remain_in [READER_SLOTS];
   logic [READER_SLOTS-1:0] id_hit;
   logic                    pending_now;

   // Match the id and look for unfinished replay
   always_comb begin
      pending_now = 1'b0;
      for (int i = 0; i < READER_SLOTS; i++) begin
         id_hit[i] = valid_ff[i] && (reader_ff[i] == req.id);
         if (valid_ff[i] && (remain_ff[i] != '0)) begin
            pending_now = 1'b1;
         end
      end
   end

   // Apply one operation to the table
   always_comb begin
      logic found;
      found     = 1'b0;
      valid_in  = valid_ff;
      reader_in = reader_ff;
      cursor_in = cursor_ff;
      remain_in = remain_ff;
      rsp       = '0;
      if (req.accept) begin
         case (req.opcode)
            OP_RECORD: begin
               rsp.success = !pending_now;
               rsp.rec_en  = !pending_now;
            end
            OP_ATTACH: begin
               if (id_hit != '0) begin
                  rsp.success = 1'b1;
               end else begin
                  for (int i = 0; i < READER_SLOTS; i++) begin
                     if (!found && !valid_ff[i]) begin
                        found        = 1'b1;
                        valid_in[i]  = 1'b1;
                        reader_in[i] = req.id;
                        cursor_in[i] = ring_start;
                        remain_in[i] = ring_count;
                     end
                  end
                  rsp.success = found;
               end
            end
            OP_DETACH: begin
               for (int i = 0; i < READER_SLOTS; i++) begin
                  if (id_hit[i]) begin
                     valid_in[i]  = 1'b0;
                     cursor_in[i] = '0;
                     remain_in[i] = '0;
                  end
               end
               rsp.success = 1'b1;
            end
            OP_FETCH: begin
               for (int i = 0; i < READER_SLOTS; i++) begin
                  if ((int'(req.slot) == i) && valid_ff[i]) begin
                     rsp.rid = reader_ff[i];
                     if (remain_ff[i] != '0) begin
                        rsp.success  = 1'b1;
                        rsp.rd_en    = 1'b1;
                        rsp.rd_addr  = cursor_ff[i];
                        remain_in[i] = remain_ff[i] - CNT_W'(1);
                        if (cursor_ff[i] == PTR_W'(HISTORY_DEPTH - 1)) begin
                           cursor_in[i] = '0;
                        end else begin
                           cursor_in[i] = cursor_ff[i] + PTR_W'(1);
                        end
                     end
                     rsp.rem  = REM_W'(remain_in[i]);
                     rsp.live = (remain_in[i] == '0);
                  end
               end
            end
            default: begin
               rsp.success = 1'b0;
            end
         endcase
      end
      // Summaries after this step
      for (int i = 0; i < READER_SLOTS; i++) begin
         rsp.rcount = rsp.rcount + RCNT_W'(valid_in[i]);
         if (valid_in[i] && (remain_in[i] != '0)) begin
            rsp.pending = 1'b1;
         end
      end
   end

   // Control state of each slot
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < READER_SLOTS; i++) begin
            cursor_ff[i] <= '0;
            remain_ff[i] <= '0;
         end
      end else begin
         valid_ff  <= valid_in;
         cursor_ff <= cursor_in;
         remain_ff <= remain_in;
      end
   end

   // Reader ids carry no reset
   always_ff @(posedge clock) begin
      reader_ff <= reader_in;
   end

   `HRMR_CHECK(no_record_during_replay,
      req.accept && (req.opcode == OP_RECORD) && pending_now, !rsp.rec_en)
   `HRMR_CHECK_NEXT(count_tracks_valid, req.accept,
      $countones(valid_ff) == int'($past(rsp.rcount)))
   `HRMR_CHECK(fetch_addr_in_ring, rsp.rd_en, rsp.rd_addr < PTR_W'(HISTORY_DEPTH))

endmodule

// File: rtl/history_ring_multi_reader.sv
// A result passes through stage one and then the output register before it reaches the rsp ports.
// Throughput: one item per cycle while rsp_ready is held high; each fetch uses the ring memory's
// single read port once, and the result stage drains one item per cycle unless rsp_ready stalls it.
// Reset: synchronous, active high; empties the ring and frees every reader slot.
// Ring memory contents are not cleared; entries are only read after being recorded.
// Top level of the history ring with multiple reader slots.
`include "history_ring_multi_reader_assert.svh"

module history_ring_multi_reader
   import hrmr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [OP_W-1:0]   req_opcode,
   input  logic [ID_W-1:0]   req_reader_id,
   input  logic [SLOT_W-1:0] req_slot,
   input  logic [PAY_W-1:0]  req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_success,
   output logic [ID_W-1:0]   rsp_out_reader_id,
   output logic [PAY_W-1:0]  rsp_out_payload,
   output logic [REM_W-1:0]  rsp_remaining_after,
   output logic              rsp_live_ready,
   output logic [RCNT_W-1:0] rsp_reader_count,
   output logic              rsp_replay_pending
);

   st_req_type            st_req;
   st_rsp_type            st_rsp;
   logic [PTR_W-1:0]      ring_start;
   logic [CNT_W-1:0]      ring_count;
   logic [PTR_W-1:0]      wr_addr;
   logic [WORD_WIDTH-1:0] rd_data;
   logic                  accept;
   logic                  p1_move;

   // Stage one: operation done, ring word in flight
   logic              p1_valid_ff, p1_valid_in;
   logic              p1_success_ff;
   logic [ID_W-1:0]   p1_rid_ff;
   logic [REM_W-1:0]  p1_rem_ff;
   logic              p1_live_ff;
   logic [RCNT_W-1:0] p1_rcount_ff;
   logic              p1_pending_ff;
   logic              p1_word_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_success_ff;
   logic [ID_W-1:0]   rsp_rid_ff;
   logic [PAY_W-1:0]  rsp_payload_ff, rsp_payload_in;
   logic [REM_W-1:0]  rsp_rem_ff;
   logic              rsp_live_ff;
   logic [RCNT_W-1:0] rsp_rcount_ff;
   logic              rsp_pending_ff;

   // Handshake: stage one drains whenever the output register frees up
   assign p1_move   = p1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !p1_valid_ff || p1_move;
   assign accept    = req_valid && req_ready;

   assign st_req.accept = accept;
   assign st_req.opcode = req_opcode;
   assign st_req.id     = req_reader_id;
   assign st_req.slot   = req_slot;

   hrmr_slot_table u_slots (
      .clock      (clock),
      .reset      (reset),
      .req        (st_req),
      .ring_start (ring_start),
      .ring_count (ring_count),
      .rsp        (st_rsp)
   );

   hrmr_ring_ctrl u_ring (
      .clock      (clock),
      .reset      (reset),
      .rec_en     (st_rsp.rec_en),
      .ring_start (ring_start),
      .ring_count (ring_count),
      .wr_addr    (wr_addr)
   );

   hrmr_ram #(
      .DEPTH (HISTORY_DEPTH),
      .WIDTH (WORD_WIDTH),
      .AW    (PTR_W)
   ) u_history (
      .clock   (clock),
      .wr_en   (st_rsp.rec_en),
      .wr_addr (wr_addr),
      .wr_data (req_payload[WORD_WIDTH-1:0]),
      .rd_en   (st_rsp.rd_en),
      .rd_addr (st_rsp.rd_addr),
      .rd_data (rd_data)
   );

   // Advance stage one valid
   always_comb begin
      p1_valid_in = p1_valid_ff;
      if (accept) begin
         p1_valid_in = 1'b1;
      end else if (p1_move) begin
         p1_valid_in = 1'b0;
      end
   end

   // Advance output valid and select the delivered word
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (p1_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      rsp_payload_in = p1_word_ff ? PAY_W'(rd_data) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the answer on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         p1_success_ff <= st_rsp.success;
         p1_rid_ff     <= st_rsp.rid;
         p1_rem_ff     <= st_rsp.rem;
         p1_live_ff    <= st_rsp.live;
         p1_rcount_ff  <= st_rsp.rcount;
         p1_pending_ff <= st_rsp.pending;
         p1_word_ff    <= st_rsp.rd_en;
      end
   end

   // Move stage one into the output register
   always_ff @(posedge clock) begin
      if (p1_move) begin
         rsp_success_ff <= p1_success_ff;
         rsp_rid_ff     <= p1_rid_ff;
         rsp_payload_ff <= rsp_payload_in;
         rsp_rem_ff     <= p1_rem_ff;
         rsp_live_ff    <= p1_live_ff;
         rsp_rcount_ff  <= p1_rcount_ff;
         rsp_pending_ff <= p1_pending_ff;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_success         = rsp_success_ff;
   assign rsp_out_reader_id   = rsp_rid_ff;
   assign rsp_out_payload     = rsp_payload_ff;
   assign rsp_remaining_after = rsp_rem_ff;
   assign rsp_live_ready      = rsp_live_ff;
   assign rsp_reader_count    = rsp_rcount_ff;
   assign rsp_replay_pending  = rsp_pending_ff;

   `HRMR_CHECK(stalled_stage_blocks_input, p1_valid_ff && !p1_move, !req_ready)
   `HRMR_CHECK_NEXT(fetch_read_lands, st_rsp.rd_en, p1_valid_ff && p1_word_ff)
   `HRMR_CHECK(live_means_drained, rsp_valid_ff && rsp_live_ff, rsp_rem_ff == '0)

endmodule

// File: test/history_ring_multi_reader_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the history ring with reader slots.

module history_ring_multi_reader_test;
   import hrmr_pkg::*;

   localparam int RANDOM_ITEMS = 1150;
   localparam int RUN_LIMIT    = 200000;
   localparam int DRAIN_CYCLES = 8;

   // One result of the block, field for field.
   typedef struct packed {
      logic              success;
      logic [ID_W-1:0]   reader_id;
      logic [PAY_W-1:0]  payload;
      logic [REM_W-1:0]  remaining;
      logic              live;
      logic [RCNT_W-1:0] readers;
      logic              pending;
   } ring_result_type;

   // Tracks ring and slot state, predicts each result and checks what comes out.
   class ring_scoreboard_type;
      logic [PAY_W-1:0] words [HISTORY_DEPTH];
      int               head;
      int               fill;
      bit               attached [READER_SLOTS];
      logic [ID_W-1:0]  owner [READER_SLOTS];
      int               cursor [READER_SLOTS];
      int               left [READER_SLOTS];
      ring_result_type  awaited_results [$];
      int               failures;

      function new();
         head = 0;
         fill = 0;
         failures = 0;
         foreach (attached[i]) begin
            attached[i] = 0;
            owner[i] = '0;
            cursor[i] = 0;
            left[i] = 0;
         end
      endfunction

      function bit replay_waiting();
         foreach (attached[i])
            if (attached[i] && left[i] != 0)
               return 1;
         return 0;
      endfunction

      function int attached_count();
         int n;
         n = 0;
         foreach (attached[i])
            if (attached[i])
               n++;
         return n;
      endfunction

      // Pick a random slot that still has words to replay.
      function int replaying_slot();
         int picks [$];
         foreach (attached[i])
            if (attached[i] && left[i] != 0)
               picks.push_back(i);
         return picks[$urandom_range(0, picks.size() - 1)];
      endfunction

      function int outstanding();
         return awaited_results.size();
      endfunction

      // Apply one accepted transfer and queue the result it should produce.
      function void note_request(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                 logic [SLOT_W-1:0] sl, logic [PAY_W-1:0] word);
         ring_result_type r;
         bit              found;
         int              pos;
         r = '0;
         found = 0;
         case (op)
            OP_RECORD: begin
               // Ring stays frozen while any reader is replaying.
               if (!replay_waiting()) begin
                  pos = (head + fill) % HISTORY_DEPTH;
                  words[pos] = word;
                  if (fill < HISTORY_DEPTH)
                     fill++;
                  else
                     head = (head + 1) % HISTORY_DEPTH;
                  r.success = 1'b1;
               end
            end
            OP_ATTACH: begin
               foreach (attached[i])
                  if (attached[i] && owner[i] == id)
                     found = 1;
               if (found) begin
                  r.success = 1'b1;
               end else begin
                  // Take the lowest free slot and snapshot the ring.
                  for (int i = 0; i < READER_SLOTS; i++) begin
                     if (!attached[i]) begin
                        attached[i] = 1;
                        owner[i] = id;
                        cursor[i] = head;
                        left[i] = fill;
                        r.success = 1'b1;
                        break;
                     end
                  end
               end
            end
            OP_DETACH: begin
               foreach (attached[i]) begin
                  if (attached[i] && owner[i] == id) begin
                     attached[i] = 0;
                     owner[i] = '0;
                     cursor[i] = 0;
                     left[i] = 0;
                  end
               end
               r.success = 1'b1;
            end
            OP_FETCH: begin
               if (sl < READER_SLOTS && attached[sl]) begin
                  r.reader_id = owner[sl];
                  if (left[sl] != 0) begin
                     r.payload = words[cursor[sl]];
                     cursor[sl] = (cursor[sl] + 1) % HISTORY_DEPTH;
                     left[sl]--;
                     r.success = 1'b1;
                  end
                  r.remaining = REM_W'(left[sl]);
                  r.live = (left[sl] == 0);
               end
            end
         endcase
         r.readers = RCNT_W'(attached_count());
         r.pending = replay_waiting();
         awaited_results.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            failures++;
            if (failures <= 10)
               $display("mismatch on %s: expected %h, actual %h", name, want, got);
         end
      endfunction

      // Match a result transfer against the oldest prediction.
      function void check_response(ring_result_type got);
         ring_result_type want;
         if (awaited_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("result with nothing awaited: %p", got);
            return;
         end
         want = awaited_results.pop_front();
         compare_field("success", 64'(want.success), 64'(got.success));
         compare_field("out_reader_id", 64'(want.reader_id), 64'(got.reader_id));
         compare_field("out_payload", want.payload, got.payload);
         compare_field("remaining_after", 64'(want.remaining), 64'(got.remaining));
         compare_field("live_ready", 64'(want.live), 64'(got.live));
         compare_field("reader_count", 64'(want.readers), 64'(got.readers));
         compare_field("replay_pending", 64'(want.pending), 64'(got.pending));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_opcode = OP_RECORD;
   logic [ID_W-1:0]   req_reader_id = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [PAY_W-1:0]  req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic              rsp_success;
   logic [ID_W-1:0]   rsp_out_reader_id;
   logic [PAY_W-1:0]  rsp_out_payload;
   logic [REM_W-1:0]  rsp_remaining_after;
   logic              rsp_live_ready;
   logic [RCNT_W-1:0] rsp_reader_count;
   logic              rsp_replay_pending;

   ring_scoreboard_type sb;
   int                  cycle_count = 0;
   int                  burst_left = 0;
   logic [ID_W-1:0]     id_pool [8];

   history_ring_multi_reader dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_opcode          (req_opcode),
      .req_reader_id       (req_reader_id),
      .req_slot            (req_slot),
      .req_payload         (req_payload),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_success         (rsp_success),
      .rsp_out_reader_id   (rsp_out_reader_id),
      .rsp_out_payload     (rsp_out_payload),
      .rsp_remaining_after (rsp_remaining_after),
      .rsp_live_ready      (rsp_live_ready),
      .rsp_reader_count    (rsp_reader_count),
      .rsp_replay_pending  (rsp_replay_pending)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Check result transfers and stall the result side in shifting patterns.
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && rsp_valid && rsp_ready)
         sb.check_response({rsp_success, rsp_out_reader_id, rsp_out_payload,
                            rsp_remaining_after, rsp_live_ready, rsp_reader_count,
                            rsp_replay_pending});
      case ((cycle_count / 150) % 4)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 9) < 7);
         2: rsp_ready <= (cycle_count % 5 != 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   // Hold one request until it transfers, then maybe pause between bursts.
   task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                        input logic [SLOT_W-1:0] sl, input logic [PAY_W-1:0] pay);
      int gap;
      req_valid <= 1'b1;
      req_opcode <= op;
      req_reader_id <= id;
      req_slot <= sl;
      req_payload <= pay;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      sb.note_request(op, id, sl, pay);
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop sending until every predicted result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0)
         @(posedge clock);
   endtask

   // Mostly well-formed traffic driven by the tracked state, some noise.
   task automatic pick_item(output logic [OP_W-1:0] op, output logic [ID_W-1:0] id,
                            output logic [SLOT_W-1:0] sl, output logic [PAY_W-1:0] pay);
      int roll;
      int busy;
      op = OP_RECORD;
      id = id_pool[$urandom_range(0, 7)];
      sl = SLOT_W'($urandom_range(0, READER_SLOTS - 1));
      pay = {$urandom, $urandom};
      roll = $urandom_range(0, 99);
      if (roll < 10) begin
         op = OP_W'($urandom_range(0, 3));
         id = ID_W'($urandom);
         sl = SLOT_W'($urandom_range(0, 7));
      end else if (sb.replay_waiting()) begin
         busy = sb.replaying_slot();
         if (roll < 86) begin
            op = OP_FETCH;
            sl = SLOT_W'(busy);
         end else if (roll < 91) begin
            op = OP_DETACH;
            id = sb.owner[busy];
         end else if (roll < 95) begin
            op = OP_ATTACH;
         end
      end else begin
         if (roll < 72)
            op = OP_RECORD;
         else if (roll < 80)
            op = OP_ATTACH;
         else if (roll < 88)
            op = OP_DETACH;
         else
            op = OP_FETCH;
      end
   endtask

   initial begin
      logic [OP_W-1:0]   op;
      logic [ID_W-1:0]   id;
      logic [SLOT_W-1:0] sl;
      logic [PAY_W-1:0]  pay;
      sb = new();
      id_pool[0] = 16'h0000;
      id_pool[1] = 16'hFFFF;
      id_pool[2] = 16'h0001;
      id_pool[3] = 16'h8000;
      for (int i = 4; i < 8; i++)
         id_pool[i] = ID_W'($urandom);

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty table, extremes of the fields, frozen ring, full table.
      issue(OP_FETCH, 16'h0000, 3'd0, '0);
      issue(OP_FETCH, 16'h0000, 3'd7, '0);
      issue(OP_FETCH, 16'h0000, 3'd5, '0);
      issue(OP_ATTACH, 16'h0000, 3'd0, '0);
      issue(OP_FETCH, 16'h0000, 3'd0, '0);
      issue(OP_RECORD, 16'h0000, 3'd0, 64'h0);
      issue(OP_RECORD, 16'hFFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
      issue(OP_RECORD, 16'h0000, 3'd0, 64'h5555_AAAA_5555_AAAA);
      issue(OP_ATTACH, 16'hFFFF, 3'd0, '0);
      issue(OP_ATTACH, 16'hFFFF, 3'd0, '0);
      issue(OP_RECORD, 16'h0000, 3'd0, 64'h1234_5678_9ABC_DEF0);
      issue(OP_FETCH, 16'h0000, 3'd1, '0);
      issue(OP_DETACH, 16'h1234, 3'd0, '0);
      issue(OP_ATTACH, 16'h0001, 3'd0, '0);
      issue(OP_ATTACH, 16'h0002, 3'd0, '0);
      issue(OP_ATTACH, 16'h0003, 3'd0, '0);
      issue(OP_ATTACH, 16'h0004, 3'd0, '0);
      issue(OP_FETCH, 16'h0000, 3'd1, '0);
      issue(OP_FETCH, 16'h0000, 3'd1, '0);
      issue(OP_FETCH, 16'h0000, 3'd1, '0);
      issue(OP_DETACH, 16'hFFFF, 3'd0, '0);
      issue(OP_FETCH, 16'h0000, 3'd1, '0);
      issue(OP_DETACH, 16'h0001, 3'd0, '0);
      issue(OP_DETACH, 16'h0002, 3'd0, '0);
      issue(OP_DETACH, 16'h0003, 3'd0, '0);
      wait_for_results();

      // Random traffic, with a full drain now and then.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 300 == 150)
            wait_for_results();
         pick_item(op, id, sl, pay);
         issue(op, id, sl, pay);
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   // Give up on a hung run.
   initial begin
      wait (cycle_count >= RUN_LIMIT);
      $display("Verification failed");
      $finish;
   end

endmodule

// File: files.f
+incdir+rtl
rtl/hrmr_pkg.sv
rtl/hrmr_ram.sv
rtl/hrmr_ring_ctrl.sv
rtl/hrmr_slot_table.sv
rtl/history_ring_multi_reader.sv
test/history_ring_multi_reader_test.sv
